@@ sv/rlqt_pkg.sv @@
// Package for the ranging link quality tracker.
// Holds the window size, derived widths and the control and status structs.
// Used by every module of the block; depends on nothing.
`default_nettype none
package rlqt_pkg;

  localparam int QUALITY_WINDOW = 32;
  localparam int RCW = $clog2(QUALITY_WINDOW + 1);
  localparam int QBITS = 7;
  localparam int DIVW = RCW + QBITS;
  localparam int CNTW = $clog2(QBITS);
  localparam int DISTW = 24;
  localparam int TOTW = 32;
  localparam logic [QBITS-1:0] PERCENT_SCALE = QBITS'(100);
  localparam logic [RCW:0] WINDOW_LIMIT = (RCW + 1)'(QUALITY_WINDOW);

  typedef enum logic {
    CmdSuccess = 1'b0,
    CmdFailure = 1'b1
  } command_e;

  typedef struct packed {
    logic [DISTW-1:0] estimate;
    logic             seen;
    logic [RCW-1:0]   recent_succ;
    logic [RCW-1:0]   window_count;
    logic [TOTW-1:0]  total;
  } stats_t;

  typedef struct packed {
    logic start;
    logic take;
  } div_ctrl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

@@ sv/rlqt_stats.sv @@
// Outcome counters of the ranging link quality tracker.
// Keeps the recent window, the attempt count and the latest estimate.
// Depends on rlqt_pkg.
`default_nettype none
module rlqt_stats (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     update_i,
  input  wire logic                     command_i,
  input  wire logic [rlqt_pkg::DISTW-1:0] distance_i,
  output rlqt_pkg::stats_t              stats_o
);
  import rlqt_pkg::*;

  logic [RCW-1:0]   succ_q, succ_d, fail_q, fail_d;
  logic [RCW-1:0]   succ_h, fail_h;
  logic [RCW:0]     sum, succ_inc;
  logic [TOTW-1:0]  total_q;
  logic [DISTW-1:0] est_q;
  logic             seen_q;

  always_comb begin
    sum = {1'b0, succ_q} + {1'b0, fail_q};
    succ_inc = {1'b0, succ_q} + (RCW + 1)'(1);
    if (sum >= WINDOW_LIMIT) begin
      succ_h = succ_inc[RCW:1];
      fail_h = {1'b0, fail_q[RCW-1:1]};
    end else begin
      succ_h = succ_q;
      fail_h = fail_q;
    end
    succ_d = succ_h;
    fail_d = fail_h;
    if (command_i == CmdSuccess) begin
      succ_d = succ_h + RCW'(1);
    end else begin
      fail_d = fail_h + RCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      succ_q  <= '0;
      fail_q  <= '0;
      total_q <= '0;
      est_q   <= '0;
      seen_q  <= 1'b0;
    end else if (update_i) begin
      succ_q  <= succ_d;
      fail_q  <= fail_d;
      total_q <= total_q + TOTW'(1);
      if (command_i == CmdSuccess) begin
        est_q  <= distance_i;
        seen_q <= 1'b1;
      end
    end
  end

  logic [RCW:0] recent_sum;
  assign recent_sum = {1'b0, succ_q} + {1'b0, fail_q};

  assign stats_o.estimate     = est_q;
  assign stats_o.seen         = seen_q;
  assign stats_o.recent_succ  = succ_q;
  assign stats_o.window_count = recent_sum[RCW-1:0];
  assign stats_o.total        = total_q;

endmodule
`default_nettype wire

@@ sv/rlqt_div.sv @@
// Bit-serial restoring divider for the quality percent.
// Produces one quotient bit per cycle, most significant first.
// Depends on rlqt_pkg.
`default_nettype none
module rlqt_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire rlqt_pkg::div_ctrl_t       ctrl_i,
  input  wire logic [rlqt_pkg::DIVW-1:0] dividend_i,
  input  wire logic [rlqt_pkg::RCW-1:0]  divisor_i,
  output rlqt_pkg::div_stat_t            stat_o,
  output logic [rlqt_pkg::QBITS-1:0]     quotient_o
);
  import rlqt_pkg::*;

  typedef enum logic [1:0] {
    DivIdle,
    DivRun,
    DivDone
  } div_state_e;

  div_state_e       state_q;
  logic [DIVW-1:0]  rem_q, dv_q;
  logic [QBITS-1:0] quot_q;
  logic [CNTW-1:0]  cnt_q;
  logic             zero_q;
  logic             fits;

  assign fits = rem_q >= dv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DivIdle;
      rem_q   <= '0;
      dv_q    <= '0;
      quot_q  <= '0;
      cnt_q   <= '0;
      zero_q  <= 1'b0;
    end else begin
      unique case (state_q)
        DivIdle: begin
          if (ctrl_i.start) begin
            rem_q   <= dividend_i;
            dv_q    <= DIVW'({divisor_i, {(QBITS-1){1'b0}}});
            quot_q  <= '0;
            cnt_q   <= CNTW'(QBITS - 1);
            zero_q  <= (divisor_i == '0);
            state_q <= DivRun;
          end
        end
        DivRun: begin
          if (fits) begin
            rem_q <= rem_q - dv_q;
          end
          quot_q <= {quot_q[QBITS-2:0], fits};
          dv_q   <= dv_q >> 1;
          cnt_q  <= cnt_q - CNTW'(1);
          if (cnt_q == '0) begin
            state_q <= DivDone;
          end
        end
        DivDone: begin
          if (ctrl_i.take) begin
            state_q <= DivIdle;
          end
        end
        default: state_q <= DivIdle;
      endcase
    end
  end

  assign stat_o.idle = (state_q == DivIdle);
  assign stat_o.done = (state_q == DivDone);
  assign quotient_o  = zero_q ? '0 : quot_q;

endmodule
`default_nettype wire

@@ sv/ranging_link_quality_tracker.sv @@
// Top level of the ranging link quality tracker.
// Ties the outcome counters to the serial divider and the result register.
// Depends on rlqt_pkg, rlqt_stats and rlqt_div.
//
// Usage: each request on the slave stream is one ranging outcome. tuser
// carries the command (0 = success, 1 = failure) and tdata the distance in
// millimetres. Every request yields exactly one result on the master stream
// with the latest estimate, its valid flag, the quality percent of the recent
// window and the lifetime attempt count.
// Flow: the counters update on the accepting edge, the divider starts in the
// next cycle and yields one quotient bit per cycle, most significant first;
// the result is registered once the divider is done and the output register
// is free. A new request is taken as soon as its predecessor has moved to the
// output register, so the block takes no new request while one is in
// flight.
// Reset clears all counters, the estimate and the output register; no
// request is in flight afterwards. When the receiver stalls, the result is
// held in the output register, and the next request runs through the
// divider and then waits there until the output register is taken.
`default_nettype none
module ranging_link_quality_tracker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: distance_mm [23:0]
  input  wire logic [23:0] s_axis_tdata,
  // tuser: command [0]
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: estimate_mm [23:0], estimate_valid [24], quality_percent [31:25],
  // total_attempts [63:32]
  output logic [63:0]      m_axis_tdata
);
  import rlqt_pkg::*;

  stats_t           stats;
  div_ctrl_t        div_ctrl;
  div_stat_t        div_stat;
  logic [QBITS-1:0] quotient;
  logic [DIVW-1:0]  dividend;
  logic             accept, load_out;
  logic             busy_q, start_q, out_valid_q;
  logic [63:0]      out_data_q;

  assign s_axis_tready = !busy_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign load_out      = div_stat.done && (!out_valid_q || m_axis_tready);
  assign dividend      = DIVW'(stats.recent_succ) * DIVW'(PERCENT_SCALE);

  assign div_ctrl.start = start_q;
  assign div_ctrl.take  = load_out;

  rlqt_stats u_stats (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .update_i   (accept),
    .command_i  (s_axis_tuser),
    .distance_i (s_axis_tdata),
    .stats_o    (stats)
  );

  rlqt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (dividend),
    .divisor_i  (stats.window_count),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      start_q <= accept;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (load_out) begin
        busy_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
        out_data_q  <= {stats.total, quotient, stats.seen, stats.estimate};
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q && start_q && div_stat.idle)
    else $error("accepted request did not start the divider");

  a_idle_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> div_stat.idle && !start_q)
    else $error("divider active without a request in flight");

  a_quality_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> quotient <= PERCENT_SCALE)
    else $error("quality percent above one hundred");

  a_load_clears_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> !busy_q && m_axis_tvalid)
    else $error("result load did not release the input");

endmodule
`default_nettype wire
